>>> design/logic_formula_syntax_checker_defines.svh
// Assertion macros shared by the formula syntax checker.
// Needs nothing else; the bodies vanish when SYNTHESIS is defined.
`ifndef LOGIC_FORMULA_SYNTAX_CHECKER_DEFINES_SVH
`define LOGIC_FORMULA_SYNTAX_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define LFSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("formula checker: same-cycle check failed");
// Next-cycle implication under reset.
`define LFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("formula checker: next-cycle check failed");
`else
`define LFSC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/lfsc_pkg.sv
// Types, constants and helper functions of the formula syntax checker.
// Depends on nothing; used by the interfaces, the checker core and the top level.
package lfsc_pkg;

    localparam int SYMBOL_W  = 8;
    localparam int STATUS_W  = 4;
    localparam int MAX_DEPTH = 255;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

    // ASCII codes of the symbols.
    localparam logic [SYMBOL_W-1:0] CHAR_OPEN  = 8'h28;
    localparam logic [SYMBOL_W-1:0] CHAR_CLOSE = 8'h29;
    localparam logic [SYMBOL_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYMBOL_W-1:0] CHAR_EQ    = 8'h3D;
    localparam logic [SYMBOL_W-1:0] CHAR_NOT   = 8'h21;
    localparam logic [SYMBOL_W-1:0] CHAR_A     = 8'h41;
    localparam logic [SYMBOL_W-1:0] CHAR_Z     = 8'h5A;

    typedef enum logic [3:0] {
        CL_NONE  = 4'd0,
        CL_OPEN  = 4'd1,
        CL_CLOSE = 4'd2,
        CL_PLUS  = 4'd3,
        CL_STAR  = 4'd4,
        CL_MINUS = 4'd5,
        CL_EQ    = 4'd6,
        CL_NOT   = 4'd7,
        CL_VAR   = 4'd8,
        CL_BAD   = 4'd9
    } class_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 4'd0,
        ST_START     = 4'd1,
        ST_AFTER_OPN = 4'd2,
        ST_AFTER_CLS = 4'd3,
        ST_AFTER_PLS = 4'd4,
        ST_AFTER_STR = 4'd5,
        ST_AFTER_MIN = 4'd6,
        ST_AFTER_EQ  = 4'd7,
        ST_AFTER_NOT = 4'd8,
        ST_AFTER_VAR = 4'd9,
        ST_INVALID   = 4'd10,
        ST_UNBAL     = 4'd11,
        ST_DEEP      = 4'd12
    } status_t;

    // State that the checker core reads and proposes to write.
    typedef struct packed {
        class_t             prev_class;
        logic [DEPTH_W-1:0] depth;
    } parse_state_t;

    typedef struct packed {
        status_t      status;
        parse_state_t state;
    } check_result_t;

    function automatic class_t classify(input logic [SYMBOL_W-1:0] c);
        class_t k;
        if (c >= CHAR_A && c <= CHAR_Z) begin
            k = CL_VAR;
        end else begin
            case (c)
                CHAR_OPEN:  k = CL_OPEN;
                CHAR_CLOSE: k = CL_CLOSE;
                CHAR_PLUS:  k = CL_PLUS;
                CHAR_STAR:  k = CL_STAR;
                CHAR_MINUS: k = CL_MINUS;
                CHAR_EQ:    k = CL_EQ;
                CHAR_NOT:   k = CL_NOT;
                default:    k = CL_BAD;
            endcase
        end
        return k;
    endfunction

    // Symbols that cannot open an operand: close and the binary operators.
    function automatic logic closer_or_binary(input class_t k);
        return k inside {CL_CLOSE, CL_PLUS, CL_STAR, CL_MINUS, CL_EQ};
    endfunction

    function automatic logic pair_forbidden(input class_t prev, input class_t k);
        logic bad;
        case (prev)
            CL_NONE:  bad = 1'b0;
            CL_CLOSE: bad = k inside {CL_OPEN, CL_VAR};
            CL_VAR:   bad = k inside {CL_NOT, CL_OPEN, CL_VAR};
            default:  bad = closer_or_binary(k);
        endcase
        return bad;
    endfunction

    // Error code naming the earlier symbol of a forbidden pair, or the last symbol of a formula.
    function automatic status_t follower_status(input class_t k);
        status_t s;
        case (k)
            CL_OPEN:  s = ST_AFTER_OPN;
            CL_CLOSE: s = ST_AFTER_CLS;
            CL_PLUS:  s = ST_AFTER_PLS;
            CL_STAR:  s = ST_AFTER_STR;
            CL_MINUS: s = ST_AFTER_MIN;
            CL_EQ:    s = ST_AFTER_EQ;
            CL_NOT:   s = ST_AFTER_NOT;
            CL_VAR:   s = ST_AFTER_VAR;
            default:  s = ST_OK;
        endcase
        return s;
    endfunction

endpackage

>>> design/lfsc_symbol_if.sv
// Valid/ready channel that carries one formula symbol per request.
// Depends on lfsc_pkg for the field widths.
interface lfsc_symbol_if;
    import lfsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

>>> design/lfsc_verdict_if.sv
// Valid/ready channel that carries one verdict per request.
// Depends on lfsc_pkg for the field widths.
interface lfsc_verdict_if;
    import lfsc_pkg::*;

    logic                valid;
    logic                ready;
    logic                decided;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output decided, output status, input ready);
    modport sink   (input valid, input decided, input status, output ready);
endinterface

>>> design/logic_formula_syntax_checker.sv
// Propositional formula syntax checker: one ASCII symbol per request in, one verdict out.
// Depends on lfsc_pkg, lfsc_symbol_if, lfsc_verdict_if, lfsc_check and the defines header.
//
// Symbols stream in one per request, with last_symbol marking the end of a formula, and
// every symbol yields exactly one registered verdict. The block takes one symbol in every
// clock cycle unless stalled: the class of the previous symbol and the nesting counter are
// updated in the same cycle the symbol is taken, and a single output register holds the
// verdict, so a new symbol is accepted whenever that register is empty or being drained.
// The first error of a formula is reported once with decided high; later symbols of that
// formula carry the held code with decided low until its last symbol restarts the checker.
`include "logic_formula_syntax_checker_defines.svh"

module logic_formula_syntax_checker (
    input  logic           clk,
    input  logic           rst_n,
    lfsc_symbol_if.sink    symbols,
    lfsc_verdict_if.source verdicts
);
    import lfsc_pkg::*;

    parse_state_t  state_reg, state_next;
    logic          error_seen_reg, error_seen_next;
    status_t       held_status_reg, held_status_next;
    logic          out_valid_reg, out_valid_next;
    logic          decided_reg, decided_next;
    status_t       status_reg, status_next;
    check_result_t chk;
    logic          in_fire;

    localparam parse_state_t START_STATE = '{prev_class: CL_NONE, depth: '0};

    // Symbol check against the current parse state.
    lfsc_check u_check (
        .symbol      (symbols.symbol),
        .last_symbol (symbols.last_symbol),
        .state       (state_reg),
        .result      (chk)
    );

    // A new request is taken while the output register is empty or being drained.
    assign symbols.ready = !out_valid_reg || verdicts.ready;
    assign in_fire       = symbols.valid && symbols.ready;

    // Next state and verdict for an accepted symbol.
    always_comb
    begin
        state_next       = state_reg;
        error_seen_next  = error_seen_reg;
        held_status_next = held_status_reg;
        out_valid_next   = out_valid_reg && !verdicts.ready;
        decided_next     = decided_reg;
        status_next      = status_reg;
        if (in_fire) begin
            out_valid_next = 1'b1;
            decided_next   = 1'b0;
            status_next    = ST_OK;
            if (error_seen_reg) begin
                status_next = held_status_reg;
                if (symbols.last_symbol) begin
                    state_next       = START_STATE;
                    error_seen_next  = 1'b0;
                    held_status_next = ST_OK;
                end
            end else if (chk.status != ST_OK) begin
                decided_next = 1'b1;
                status_next  = chk.status;
                if (symbols.last_symbol) begin
                    state_next       = START_STATE;
                    held_status_next = ST_OK;
                end else begin
                    state_next       = chk.state;
                    error_seen_next  = 1'b1;
                    held_status_next = chk.status;
                end
            end else if (symbols.last_symbol) begin
                decided_next = 1'b1;
                state_next   = START_STATE;
            end else begin
                state_next = chk.state;
            end
        end
    end

    // Control state, with asynchronous reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= START_STATE;
            error_seen_reg  <= 1'b0;
            held_status_reg <= ST_OK;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            error_seen_reg  <= error_seen_next;
            held_status_reg <= held_status_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Verdict payload register.
    always_ff @(posedge clk)
    begin
        decided_reg <= decided_next;
        status_reg  <= status_next;
    end

    assign verdicts.valid   = out_valid_reg;
    assign verdicts.decided = decided_reg;
    assign verdicts.status  = status_reg;

    // A held error always carries a real error code.
    `LFSC_ASSERT_SAME(a_held_code, clk, rst_n, error_seen_reg, held_status_reg != ST_OK)
    // An error reported before the end of a formula is held for the rest of it.
    `LFSC_ASSERT_NEXT(a_error_held, clk, rst_n,
        in_fire && !error_seen_reg && !symbols.last_symbol && chk.status != ST_OK,
        error_seen_reg && held_status_reg == $past(chk.status))
    // The end of a formula restarts the parser from a clean state.
    `LFSC_ASSERT_NEXT(a_restart, clk, rst_n, in_fire && symbols.last_symbol,
        !error_seen_reg && state_reg.depth == '0 && state_reg.prev_class == CL_NONE)
    // Nesting never goes beyond its limit.
    `LFSC_ASSERT_SAME(a_depth_limit, clk, rst_n, 1'b1, state_reg.depth <= DEPTH_LIMIT)

endmodule

>>> design/lfsc_check.sv
// Combinational check of one symbol against the previous class and the depth.
// Depends on lfsc_pkg for the class table, the pair rules and the codes.
module lfsc_check (
    input  logic [lfsc_pkg::SYMBOL_W-1:0] symbol,
    input  logic                          last_symbol,
    input  lfsc_pkg::parse_state_t        state,
    output lfsc_pkg::check_result_t       result
);
    import lfsc_pkg::*;

    class_t             cls;
    logic [DEPTH_W-1:0] depth_upd;

    // The first failing rule wins; the state is only advanced once the symbol rules all pass.
    always_comb
    begin
        cls              = classify(symbol);
        depth_upd        = state.depth;
        result.status    = ST_OK;
        result.state     = state;
        if (cls == CL_BAD) begin
            result.status = ST_INVALID;
        end else if (state.prev_class == CL_NONE && closer_or_binary(cls)) begin
            result.status = ST_START;
        end else if (pair_forbidden(state.prev_class, cls)) begin
            result.status = follower_status(state.prev_class);
        end else if (cls == CL_OPEN && state.depth >= DEPTH_LIMIT) begin
            result.status = ST_DEEP;
        end else if (cls == CL_CLOSE && state.depth == '0) begin
            result.status = ST_UNBAL;
        end else begin
            if (cls == CL_OPEN) begin
                depth_upd = state.depth + DEPTH_W'(1);
            end else if (cls == CL_CLOSE) begin
                depth_upd = state.depth - DEPTH_W'(1);
            end
            result.state.prev_class = cls;
            result.state.depth      = depth_upd;
            // End of formula: it must close on an operand with nothing left open.
            if (last_symbol) begin
                if (cls inside {CL_CLOSE, CL_VAR}) begin
                    if (depth_upd != '0) begin
                        result.status = ST_UNBAL;
                    end
                end else begin
                    result.status = follower_status(cls);
                end
            end
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the propositional formula syntax checker.
// Depends on lfsc_pkg, lfsc_symbol_if, lfsc_verdict_if and logic_formula_syntax_checker.
module testbench;
    import lfsc_pkg::*;

    typedef struct {
        logic [SYMBOL_W-1:0] symbol;
        logic                last_symbol;
        bit                  wait_idle;
    } symbol_req_t;

    typedef struct {
        logic    decided;
        status_t status;
    } verdict_t;

    logic clk;
    logic rst_n;

    lfsc_symbol_if  sym_ch ();
    lfsc_verdict_if ver_ch ();

    logic_formula_syntax_checker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .symbols  (sym_ch),
        .verdicts (ver_ch)
    );

    symbol_req_t         symbol_queue[$];
    verdict_t            verdicts_due[$];
    logic [SYMBOL_W-1:0] draft[$];
    int                  mismatches;

    // Shadow state of the checker.
    class_t  prev_kind;
    int      open_count;
    bit      in_error;
    status_t held_code;

    // Sender and receiver pacing.
    int burst_left;
    int gap_left;
    int hold_left;
    int mode;
    int mode_left;
    int verdicts_taken;

    logic [SYMBOL_W-1:0] binary_ops[4] = '{CHAR_PLUS, CHAR_STAR, CHAR_MINUS, CHAR_EQ};
    logic [SYMBOL_W-1:0] any_symbol[8] = '{CHAR_OPEN, CHAR_CLOSE, CHAR_PLUS, CHAR_STAR,
                                           CHAR_MINUS, CHAR_EQ, CHAR_NOT, CHAR_A};

    always #5 clk = ~clk;

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        sym_ch.valid = 1'b0;
        sym_ch.symbol = '0;
        sym_ch.last_symbol = 1'b0;
        ver_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Verdict predictor
    // ------------------------------------------------------------------
    function automatic class_t symbol_kind(input logic [SYMBOL_W-1:0] c);
        if (c >= CHAR_A && c <= CHAR_Z)
        begin
            return CL_VAR;
        end
        case (c)
            CHAR_OPEN:  return CL_OPEN;
            CHAR_CLOSE: return CL_CLOSE;
            CHAR_PLUS:  return CL_PLUS;
            CHAR_STAR:  return CL_STAR;
            CHAR_MINUS: return CL_MINUS;
            CHAR_EQ:    return CL_EQ;
            CHAR_NOT:   return CL_NOT;
            default:    return CL_BAD;
        endcase
    endfunction

    // The follower codes run in the same order as the symbol classes.
    function automatic status_t code_after(input class_t k);
        return status_t'(int'(k) + 1);
    endfunction

    function automatic bit cannot_follow(input class_t prev, input class_t k);
        case (prev)
            CL_NONE:  return 1'b0;
            CL_CLOSE: return k inside {CL_OPEN, CL_VAR};
            CL_VAR:   return k inside {CL_NOT, CL_OPEN, CL_VAR};
            default:  return k inside {CL_CLOSE, CL_PLUS, CL_STAR, CL_MINUS, CL_EQ};
        endcase
    endfunction

    function automatic void restart_formula();
        prev_kind = CL_NONE;
        open_count = 0;
        in_error = 1'b0;
        held_code = ST_OK;
    endfunction

    // Works out the verdict for one accepted symbol and queues it.
    function automatic void predict_verdict(input logic [SYMBOL_W-1:0] c, input logic fin);
        class_t   k;
        status_t  st;
        verdict_t v;
        k = symbol_kind(c);
        st = ST_OK;
        v.decided = 1'b0;
        v.status = ST_OK;
        if (in_error)
        begin
            v.status = held_code;
            if (fin)
            begin
                restart_formula();
            end
        end
        else
        begin
            if (k == CL_BAD)
            begin
                st = ST_INVALID;
            end
            else if (prev_kind == CL_NONE && k inside {CL_CLOSE, CL_PLUS, CL_STAR, CL_MINUS, CL_EQ})
            begin
                st = ST_START;
            end
            else if (cannot_follow(prev_kind, k))
            begin
                st = code_after(prev_kind);
            end
            else if (k == CL_OPEN && open_count >= MAX_DEPTH)
            begin
                st = ST_DEEP;
            end
            else if (k == CL_CLOSE && open_count == 0)
            begin
                st = ST_UNBAL;
            end
            else
            begin
                if (k == CL_OPEN)
                begin
                    open_count++;
                end
                else if (k == CL_CLOSE)
                begin
                    open_count--;
                end
                prev_kind = k;
                // A formula must end on an operand with every parenthesis closed.
                if (fin)
                begin
                    if (k == CL_CLOSE || k == CL_VAR)
                    begin
                        if (open_count != 0)
                        begin
                            st = ST_UNBAL;
                        end
                    end
                    else
                    begin
                        st = code_after(k);
                    end
                end
            end
            if (st != ST_OK)
            begin
                v.decided = 1'b1;
                v.status = st;
                if (fin)
                begin
                    restart_formula();
                end
                else
                begin
                    in_error = 1'b1;
                    held_code = st;
                end
            end
            else if (fin)
            begin
                v.decided = 1'b1;
                restart_formula();
            end
        end
        verdicts_due.push_back(v);
    endfunction

    // ------------------------------------------------------------------
    // Formula construction
    // ------------------------------------------------------------------
    task automatic send_formula(input bit wait_idle);
        symbol_req_t r;
        foreach (draft[i])
        begin
            r.symbol = draft[i];
            r.last_symbol = (i == draft.size() - 1);
            r.wait_idle = wait_idle && (i == 0);
            symbol_queue.push_back(r);
        end
        draft.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            draft.push_back(s[i]);
        end
        send_formula(1'b0);
    endtask

    // Appends a well-formed expression of bounded nesting to the draft.
    task automatic grow_expr(input int budget);
        int pick;
        pick = (budget <= 0) ? 0 : $urandom_range(0, 3);
        case (pick)
            0: draft.push_back(8'(CHAR_A + $urandom_range(0, 25)));
            1:
            begin
                draft.push_back(CHAR_NOT);
                grow_expr(budget - 1);
            end
            2:
            begin
                draft.push_back(CHAR_OPEN);
                grow_expr(budget - 1);
                draft.push_back(CHAR_CLOSE);
            end
            default:
            begin
                grow_expr(budget - 1);
                draft.push_back(binary_ops[$urandom_range(0, 3)]);
                grow_expr(budget - 1);
            end
        endcase
    endtask

    task automatic send_nested(input int levels);
        for (int i = 0; i < levels; i++)
        begin
            draft.push_back(CHAR_OPEN);
        end
        draft.push_back(CHAR_Z);
        for (int i = 0; i < levels; i++)
        begin
            draft.push_back(CHAR_CLOSE);
        end
        send_formula(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int random_symbols;
        int pos;
        random_symbols = 0;

        // Directed formulas: every symbol, a clean pass and a sample of the kinds of error.
        send_text("(A+B)");
        send_text("!A*Z-B=C");
        send_text(")");
        send_text("A(B");
        draft.push_back(8'h00);
        send_formula(1'b0);
        draft.push_back(8'hFF);
        send_formula(1'b0);
        send_text("A)");
        send_text("A+");
        send_text("(A");

        // Nesting right at the limit, then one level beyond it.
        send_nested(MAX_DEPTH);
        send_nested(MAX_DEPTH + 1);

        // Random formulas, mostly well formed, some damaged, some pure noise.
        while (random_symbols < 450)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6)) draft.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                grow_expr($urandom_range(0, 4));
                pos = $urandom_range(0, draft.size() - 1);
                case ($urandom_range(0, 9))
                    6: draft[pos] = 8'($urandom_range(0, 255));
                    7: draft[pos] = any_symbol[$urandom_range(0, 7)];
                    8:
                    begin
                        while (draft.size() > pos + 1)
                        begin
                            void'(draft.pop_back());
                        end
                    end
                    9: draft.insert(pos, $urandom_range(0, 1) ? CHAR_OPEN : CHAR_CLOSE);
                    default: ;
                endcase
            end
            random_symbols += draft.size();
            send_formula($urandom_range(0, 39) == 0);
        end

        while (symbol_queue.size() != 0 || sym_ch.valid !== 1'b0 || verdicts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Symbol driver: bursts of requests with random gaps between them.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive
        symbol_req_t nxt;
        if (!rst_n)
        begin
            sym_ch.valid <= 1'b0;
            sym_ch.symbol <= '0;
            sym_ch.last_symbol <= 1'b0;
            restart_formula();
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (sym_ch.valid && sym_ch.ready)
            begin
                predict_verdict(sym_ch.symbol, sym_ch.last_symbol);
            end
            if (!sym_ch.valid || sym_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sym_ch.valid <= 1'b0;
                end
                else if (symbol_queue.size() != 0
                         && (!symbol_queue[0].wait_idle || verdicts_due.size() == 0))
                begin
                    nxt = symbol_queue.pop_front();
                    sym_ch.valid <= 1'b1;
                    sym_ch.symbol <= nxt.symbol;
                    sym_ch.last_symbol <= nxt.last_symbol;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    sym_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Verdict monitor: checks each request against the oldest prediction
    // and stalls the output on a pattern of its own.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : observe
        verdict_t want;
        if (!rst_n)
        begin
            ver_ch.ready <= 1'b0;
            mismatches = 0;
            hold_left = 0;
            mode = 0;
            mode_left = 0;
            verdicts_taken = 0;
        end
        else
        begin
            if (ver_ch.valid && ver_ch.ready)
            begin
                verdicts_taken++;
                if (verdicts_due.size() == 0)
                begin
                    $error("verdict: unexpected request, decided %0b status %0d",
                           ver_ch.decided, ver_ch.status);
                    mismatches++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (ver_ch.decided !== want.decided)
                    begin
                        $error("decided: expected %0b, got %0b", want.decided, ver_ch.decided);
                        mismatches++;
                    end
                    if (ver_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, ver_ch.status);
                        mismatches++;
                    end
                end
                // Long hold-offs so that the block fills up and stalls its input.
                if (verdicts_taken == 400 || verdicts_taken == 1200)
                begin
                    hold_left = 150;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ver_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 80);
                end
                else
                begin
                    mode_left--;
                end
                case (mode)
                    0:       ver_ch.ready <= 1'b1;
                    1:       ver_ch.ready <= 1'($urandom_range(0, 1));
                    2:       ver_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: ver_ch.ready <= ~ver_ch.ready;
                endcase
            end
        end
    end

endmodule
